/* design/ppc_pkg.sv */
// Package for the polygon plane clipper: widths, register indexes,
// output source codes and the controller/datapath command and status types.
// No dependencies.
`default_nettype none
package ppc_pkg;
   localparam int COORD_W   = 32;
   localparam int DIST_W    = 64;
   localparam int PROD_W    = 65;
   localparam int T_BITS    = 30;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 3'd5;

   localparam logic [1:0] SRC_START  = 2'd0;
   localparam logic [1:0] SRC_POINT  = 2'd1;
   localparam logic [1:0] SRC_MARKER = 2'd2;

   typedef struct packed {
      logic       load;
      logic       dist_mul;
      logic       dist_acc;
      logic       int_mul;
      logic       int_acc;
      logic [1:0] axis;
      logic       save_first;
      logic       save_prev;
      logic       edge_b;
      logic       div_init;
      logic       div_step;
      logic       out_load;
      logic [1:0] out_src;
      logic       out_eop;
   } ppc_cmd_type;

   typedef struct packed {
      logic cur_in;
      logic prev_in;
      logic first_in;
      logic out_free;
   } ppc_sts_type;
endpackage
`default_nettype wire

/* design/ppc_req_if.sv */
// Vertex input channel: valid/ready handshake with one polygon vertex.
// Depends on nothing.
`default_nettype none
interface ppc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vertex_x;
   logic signed [31:0] vertex_y;
   logic signed [31:0] vertex_z;
   logic               last_vertex;
   modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
   modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface
`default_nettype wire

/* design/ppc_rsp_if.sv */
// Clipped vertex output channel: valid/ready handshake with one result item.
// Depends on nothing.
`default_nettype none
interface ppc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic               has_vertex;
   logic               end_of_polygon;
   modport source (output valid, out_x, out_y, out_z, has_vertex, end_of_polygon,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, has_vertex, end_of_polygon,
                   output ready);
endinterface
`default_nettype wire

/* design/ppc_datapath.sv */
// Clipper datapath: plane registers, vertex and distance storage, shared
// multiplier, restoring divider and output register. Uses ppc_pkg.
`default_nettype none
module ppc_datapath import ppc_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ppc_cmd_type                 cmd,
   output      ppc_sts_type                 sts,
   input  wire logic signed [COORD_W-1:0]   in_x,
   input  wire logic signed [COORD_W-1:0]   in_y,
   input  wire logic signed [COORD_W-1:0]   in_z,
   input  wire logic                        csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [COORD_W-1:0]          csr_wdata,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      logic signed [COORD_W-1:0]   out_x,
   output      logic signed [COORD_W-1:0]   out_y,
   output      logic signed [COORD_W-1:0]   out_z,
   output      logic                        out_has,
   output      logic                        out_eop
);
   logic signed [COORD_W-1:0] plane_ff [3];
   logic signed [COORD_W-1:0] normal_ff [3];
   logic signed [COORD_W-1:0] cur_ff [3];
   logic signed [COORD_W-1:0] first_ff [3];
   logic signed [COORD_W-1:0] prev_ff [3];
   logic signed [COORD_W-1:0] pt_ff [3];
   logic signed [DIST_W-1:0]  cur_dist_ff, first_dist_ff, prev_dist_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [DIST_W-1:0]         rem_ff;
   logic [T_BITS-1:0]         q_ff;
   logic                      zero_ff, one_ff;
   logic                      valid_ff;
   logic signed [COORD_W-1:0] ox_ff, oy_ff, oz_ff;
   logic                      has_ff, eop_ff;

   logic signed [COORD_W-1:0] a_v [3];
   logic signed [COORD_W-1:0] b_v [3];
   logic signed [DIST_W-1:0]  da, db, num, den;
   logic [DIST_W-1:0]         un, ud;
   logic [DIST_W:0]           rem2;
   logic [T_BITS:0]           t_val;
   logic signed [COORD_W:0]   mul_a;
   logic signed [COORD_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  dist_term, rnd, shr;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_v[i] = cmd.edge_b ? cur_ff[i] : prev_ff[i];
         b_v[i] = cmd.edge_b ? first_ff[i] : cur_ff[i];
      end
      da   = cmd.edge_b ? cur_dist_ff : prev_dist_ff;
      db   = cmd.edge_b ? first_dist_ff : cur_dist_ff;
      num  = -da;
      den  = db - da;
      un   = num[DIST_W-1] ? -num : num;
      ud   = den[DIST_W-1] ? -den : den;
      rem2 = {rem_ff, 1'b0};
      if (zero_ff) begin
         t_val = '0;
      end else if (one_ff) begin
         t_val = {1'b1, {T_BITS{1'b0}}};
      end else begin
         t_val = {1'b0, q_ff};
      end
      if (cmd.int_mul) begin
         mul_a = {b_v[cmd.axis][COORD_W-1], b_v[cmd.axis]}
               - {a_v[cmd.axis][COORD_W-1], a_v[cmd.axis]};
         mul_b = {{(COORD_W-T_BITS-1){1'b0}}, t_val};
      end else begin
         mul_a = {cur_ff[cmd.axis][COORD_W-1], cur_ff[cmd.axis]}
               - {plane_ff[cmd.axis][COORD_W-1], plane_ff[cmd.axis]};
         mul_b = normal_ff[cmd.axis];
      end
      dist_term = prod_ff >>> COORD_FRAC_BITS;
      rnd       = prod_ff + (PROD_W'(1) <<< (T_BITS - 1));
      shr       = rnd >>> T_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            plane_ff[i] <= '0;
         end
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= COORD_W'(1) <<< COORD_FRAC_BITS;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PLANE_X:  plane_ff[0]  <= csr_wdata;
            CSR_PLANE_Y:  plane_ff[1]  <= csr_wdata;
            CSR_PLANE_Z:  plane_ff[2]  <= csr_wdata;
            CSR_NORMAL_X: normal_ff[0] <= csr_wdata;
            CSR_NORMAL_Y: normal_ff[1] <= csr_wdata;
            CSR_NORMAL_Z: normal_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff[0]   <= in_x;
         cur_ff[1]   <= in_y;
         cur_ff[2]   <= in_z;
         cur_dist_ff <= '0;
      end
      if (cmd.dist_mul || cmd.int_mul) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.dist_acc) begin
         cur_dist_ff <= cur_dist_ff + dist_term[DIST_W-1:0];
      end
      if (cmd.save_first) begin
         first_ff      <= cur_ff;
         first_dist_ff <= cur_dist_ff;
      end
      if (cmd.save_prev) begin
         prev_ff      <= cur_ff;
         prev_dist_ff <= cur_dist_ff;
      end
      if (cmd.div_init) begin
         rem_ff  <= un;
         q_ff    <= '0;
         zero_ff <= (num == '0) || (num[DIST_W-1] != den[DIST_W-1]) || (den == '0);
         one_ff  <= un >= ud;
      end
      if (cmd.div_step) begin
         if (rem2 >= {1'b0, ud}) begin
            rem_ff <= DIST_W'(rem2 - {1'b0, ud});
            q_ff   <= {q_ff[T_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem2[DIST_W-1:0];
            q_ff   <= {q_ff[T_BITS-2:0], 1'b0};
         end
      end
      if (cmd.int_acc) begin
         pt_ff[cmd.axis] <= a_v[cmd.axis] + shr[COORD_W-1:0];
      end
      if (cmd.out_load) begin
         eop_ff <= cmd.out_eop;
         case (cmd.out_src)
            SRC_START: begin
               ox_ff  <= a_v[0];
               oy_ff  <= a_v[1];
               oz_ff  <= a_v[2];
               has_ff <= 1'b1;
            end
            SRC_POINT: begin
               ox_ff  <= pt_ff[0];
               oy_ff  <= pt_ff[1];
               oz_ff  <= pt_ff[2];
               has_ff <= 1'b1;
            end
            default: begin
               ox_ff  <= '0;
               oy_ff  <= '0;
               oz_ff  <= '0;
               has_ff <= 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign sts.cur_in   = !cur_dist_ff[DIST_W-1];
   assign sts.prev_in  = !prev_dist_ff[DIST_W-1];
   assign sts.first_in = !first_dist_ff[DIST_W-1];
   assign sts.out_free = !valid_ff || out_ready;

   assign out_valid = valid_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_z     = oz_ff;
   assign out_has   = has_ff;
   assign out_eop   = eop_ff;
endmodule
`default_nettype wire

/* design/ppc_ctrl.sv */
// Clipper controller: sequences distance, edge, divide, interpolate and
// emit steps and tracks whether none, one, or two or more polygon vertices have been seen. Uses ppc_pkg.
`default_nettype none
module ppc_ctrl import ppc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_last,
   output      logic        req_ready,
   input  wire ppc_sts_type sts,
   output      ppc_cmd_type cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DMUL   = 4'd1;
   localparam logic [3:0] S_DACC   = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_EA     = 4'd4;
   localparam logic [3:0] S_DINIT  = 4'd5;
   localparam logic [3:0] S_DSTEP  = 4'd6;
   localparam logic [3:0] S_IMUL   = 4'd7;
   localparam logic [3:0] S_IACC   = 4'd8;
   localparam logic [3:0] S_EP     = 4'd9;
   localparam logic [3:0] S_EDONE  = 4'd10;
   localparam logic [3:0] S_MARK   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] vc_ff, vc_in;
   logic       last_ff, last_in;
   logic       edge_ff, edge_in;
   logic       any_ff, any_in;
   logic       a_in, b_in, crossing, b_silent, final_edge;

   assign a_in       = edge_ff ? sts.cur_in : sts.prev_in;
   assign b_in       = edge_ff ? sts.first_in : sts.cur_in;
   assign crossing   = a_in ^ b_in;
   assign b_silent   = !sts.cur_in && !sts.first_in;
   assign final_edge = last_ff && (edge_ff || b_silent);
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      vc_in    = vc_ff;
      last_in  = last_ff;
      edge_in  = edge_ff;
      any_in   = any_ff;
      cmd      = '0;
      cmd.axis   = cnt_ff[1:0];
      cmd.edge_b = edge_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               any_in   = 1'b0;
               edge_in  = 1'b0;
               last_in  = req_last;
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            cmd.dist_mul = 1'b1;
            state_in     = S_DACC;
         end
         S_DACC: begin
            cmd.dist_acc = 1'b1;
            if (cnt_ff[1:0] == 2'd2) begin
               cnt_in   = '0;
               state_in = S_DECIDE;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = S_DMUL;
            end
         end
         S_DECIDE: begin
            if (last_ff && vc_ff != 2'd2) begin
               state_in = S_MARK;
            end else if (vc_ff == 2'd0) begin
               cmd.save_first = 1'b1;
               cmd.save_prev  = 1'b1;
               vc_in          = 2'd1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_EA;
            end
         end
         S_EA: begin
            if (a_in) begin
               if (sts.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_src  = SRC_START;
                  cmd.out_eop  = final_edge && !crossing;
                  any_in       = 1'b1;
                  state_in     = crossing ? S_DINIT : S_EDONE;
               end
            end else begin
               state_in = crossing ? S_DINIT : S_EDONE;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'(T_BITS - 1)) begin
               cnt_in   = '0;
               state_in = S_IMUL;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_IMUL: begin
            cmd.int_mul = 1'b1;
            state_in    = S_IACC;
         end
         S_IACC: begin
            cmd.int_acc = 1'b1;
            if (cnt_ff[1:0] == 2'd2) begin
               cnt_in   = '0;
               state_in = S_EP;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = S_IMUL;
            end
         end
         S_EP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_POINT;
               cmd.out_eop  = final_edge;
               any_in       = 1'b1;
               state_in     = S_EDONE;
            end
         end
         S_EDONE: begin
            if (!edge_ff) begin
               cmd.save_prev = 1'b1;
               vc_in         = 2'd2;
               if (last_ff && !b_silent) begin
                  edge_in  = 1'b1;
                  state_in = S_EA;
               end else if (last_ff) begin
                  vc_in    = 2'd0;
                  state_in = any_ff ? S_IDLE : S_MARK;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               vc_in    = 2'd0;
               state_in = any_ff ? S_IDLE : S_MARK;
            end
         end
         S_MARK: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_MARKER;
               cmd.out_eop  = 1'b1;
               vc_in        = 2'd0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vc_ff    <= '0;
         last_ff  <= 1'b0;
         edge_ff  <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vc_ff    <= vc_in;
         last_ff  <= last_in;
         edge_ff  <= edge_in;
         any_ff   <= any_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free) else $error("output loaded while occupied");
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DMUL) else $error("accept did not start");
   a_first_save: assert property (@(posedge clock) disable iff (reset)
      cmd.save_first |-> (vc_ff == 2'd0 && !last_ff)) else $error("bad first save");
   a_mark_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_src == SRC_MARKER) |=> vc_ff == 2'd0)
      else $error("count not cleared");
endmodule
`default_nettype wire

/* design/polygon_plane_clipper_top.sv */
// Top level of the polygon plane clipper: joins controller and datapath to
// the vertex and result channels. Uses ppc_pkg, ppc_req_if, ppc_rsp_if.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    vertex_x/y/z, last_vertex
//   rsp      out  valid/ready    out_x/y/z, has_vertex, end_of_polygon
//   csr      in   write enable   csr_index, csr_wdata
//
// A vertex goes from accept through its distance (3 multiply/accumulate
// passes on one shared multiplier, then a decide step), then per edge it ends
// a start-emit and an edge-done step, and per crossing divider setup, 30 divider
// steps, 3 interpolation passes and point emit; a marker adds an emit step.
// Reset is synchronous; config registers return to plane 0, normal +z.
// A stalled rsp holds the controller at its next emit step; req is taken
// only between vertices.
`default_nettype none
module polygon_plane_clipper_top import ppc_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   ppc_req_if.sink                   req,
   ppc_rsp_if.source                 rsp,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]   csr_wdata
);
   ppc_cmd_type cmd;
   ppc_sts_type sts;

   ppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_vertex),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ppc_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .in_x         (req.vertex_x),
      .in_y         (req.vertex_y),
      .in_z         (req.vertex_z),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .out_valid    (rsp.valid),
      .out_ready    (rsp.ready),
      .out_x        (rsp.out_x),
      .out_y        (rsp.out_y),
      .out_z        (rsp.out_z),
      .out_has      (rsp.has_vertex),
      .out_eop      (rsp.end_of_polygon)
   );
endmodule
`default_nettype wire
